@@ sv/rwn_pkg.sv @@
package rwn_pkg;

    // sizing
    localparam int DEFAULT_MAX_SAMPLES = 64;
    localparam int FW        = 20;       // result field width
    localparam int RW        = 18;       // scaled correlation magnitude width
    localparam int JW        = 5;        // root search bit index width
    localparam int OW        = RW + 1;   // odd probe width
    localparam int DOT_LIMIT = 196608;
    localparam int Q16_ONE   = 65536;
    localparam int OUT_LOW   = -131072;
    localparam int OUT_HIGH  = 262144;
    localparam int DVW       = 36;       // robust dividend width
    localparam int DSW       = 22;       // robust divisor width
    localparam int DCW       = 6;        // divider step counter width

    // controller states
    typedef enum logic [4:0] {
        ST_ACC,
        ST_PROD,
        ST_DRAIN,
        ST_CHK,
        ST_P_GO,
        ST_P_WAIT,
        ST_T_GO,
        ST_T_WAIT,
        ST_CAND,
        ST_1_GO,
        ST_1_WAIT,
        ST_2_GO,
        ST_2_WAIT,
        ST_CMP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

    // end-of-window product terms
    typedef enum logic [3:0] {
        PR_NEA = 4'd0,
        PR_NEB = 4'd1,
        PR_NX  = 4'd2,
        PR_SRA = 4'd3,
        PR_SGA = 4'd4,
        PR_SBA = 4'd5,
        PR_SRB = 4'd6,
        PR_SGB = 4'd7,
        PR_SBB = 4'd8,
        PR_XR  = 4'd9,
        PR_XG  = 4'd10,
        PR_XB  = 4'd11
    } prod_t;

    typedef enum logic [1:0] {
        G_NA,
        G_NB,
        G_C
    } grp_t;

    // serial multiplier jobs
    typedef enum logic [1:0] {
        MS_P,
        MS_T,
        MS_1,
        MS_2
    } mul_sel_t;

    typedef struct packed {
        logic            acc_en;
        logic            clear;
        logic            prod_issue;
        prod_t           prod_k;
        logic            chk;
        logic            mul_start;
        mul_sel_t        mul_sel;
        logic            store_p;
        logic            store_t;
        logic [JW-1:0]   bit_idx;
        logic            cmp_update;
        logic            div_start;
        logic            load_out;
    } cmd_t;

    typedef struct packed {
        logic zero_case;
        logic cand_ok;
        logic mul_busy;
        logic div_busy;
        logic cmp_le;
    } status_t;

endpackage

@@ sv/rwn_in_if.sv @@
interface rwn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_a;
    logic [7:0] green_a;
    logic [7:0] blue_a;
    logic [7:0] red_b;
    logic [7:0] green_b;
    logic [7:0] blue_b;
    logic       last_sample;

    modport source (
        output valid, red_a, green_a, blue_a, red_b, green_b, blue_b, last_sample,
        input  ready
    );
    modport sink (
        input  valid, red_a, green_a, blue_a, red_b, green_b, blue_b, last_sample,
        output ready
    );
endinterface

@@ sv/rwn_out_if.sv @@
interface rwn_out_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] dissimilarity;
    logic signed [19:0] robust_dissimilarity;
    logic               robust_invalid;
    logic               overflowed;

    modport source (
        output valid, dissimilarity, robust_dissimilarity, robust_invalid, overflowed,
        input  ready
    );
    modport sink (
        input  valid, dissimilarity, robust_dissimilarity, robust_invalid, overflowed,
        output ready
    );
endinterface

@@ sv/rwn_ctrl.sv @@
module rwn_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    input  logic             out_ready,
    input  rwn_pkg::status_t status,
    output rwn_pkg::cmd_t    cmd,
    output logic             in_ready,
    output logic             out_valid
);

    rwn_pkg::state_t                state_reg, state_next;
    rwn_pkg::prod_t                 k_reg;
    logic [rwn_pkg::JW-1:0]         j_reg;
    logic                           out_valid_reg;
    logic                           accept;
    logic                           emit_go;

    assign in_ready  = (state_reg == rwn_pkg::ST_ACC);
    assign accept    = in_valid && in_ready;
    assign emit_go   = (state_reg == rwn_pkg::ST_EMIT) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rwn_pkg::ST_ACC:
            begin
                if (accept && in_last)
                    state_next = rwn_pkg::ST_PROD;
            end
            rwn_pkg::ST_PROD:
            begin
                if (k_reg == rwn_pkg::PR_XB)
                    state_next = rwn_pkg::ST_DRAIN;
            end
            rwn_pkg::ST_DRAIN: state_next = rwn_pkg::ST_CHK;
            rwn_pkg::ST_CHK:
            begin
                if (status.zero_case)
                    state_next = rwn_pkg::ST_DIV_GO;
                else
                    state_next = rwn_pkg::ST_P_GO;
            end
            rwn_pkg::ST_P_GO: state_next = rwn_pkg::ST_P_WAIT;
            rwn_pkg::ST_P_WAIT:
            begin
                if (!status.mul_busy)
                    state_next = rwn_pkg::ST_T_GO;
            end
            rwn_pkg::ST_T_GO: state_next = rwn_pkg::ST_T_WAIT;
            rwn_pkg::ST_T_WAIT:
            begin
                if (!status.mul_busy)
                    state_next = rwn_pkg::ST_CAND;
            end
            rwn_pkg::ST_CAND:
            begin
                if (status.cand_ok)
                    state_next = rwn_pkg::ST_1_GO;
                else if (j_reg == '0)
                    state_next = rwn_pkg::ST_DIV_GO;
            end
            rwn_pkg::ST_1_GO: state_next = rwn_pkg::ST_1_WAIT;
            rwn_pkg::ST_1_WAIT:
            begin
                if (!status.mul_busy)
                    state_next = rwn_pkg::ST_2_GO;
            end
            rwn_pkg::ST_2_GO: state_next = rwn_pkg::ST_2_WAIT;
            rwn_pkg::ST_2_WAIT:
            begin
                if (!status.mul_busy)
                    state_next = rwn_pkg::ST_CMP;
            end
            rwn_pkg::ST_CMP:
            begin
                if (j_reg == '0)
                    state_next = rwn_pkg::ST_DIV_GO;
                else
                    state_next = rwn_pkg::ST_CAND;
            end
            rwn_pkg::ST_DIV_GO: state_next = rwn_pkg::ST_DIV_WAIT;
            rwn_pkg::ST_DIV_WAIT:
            begin
                if (!status.div_busy)
                    state_next = rwn_pkg::ST_EMIT;
            end
            rwn_pkg::ST_EMIT:
            begin
                if (emit_go)
                    state_next = rwn_pkg::ST_ACC;
            end
            default: state_next = rwn_pkg::ST_ACC;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd            = '0;
        cmd.acc_en     = accept;
        cmd.prod_k     = k_reg;
        cmd.bit_idx    = j_reg;
        unique case (state_reg)
            rwn_pkg::ST_PROD:     cmd.prod_issue = 1'b1;
            rwn_pkg::ST_CHK:      cmd.chk = 1'b1;
            rwn_pkg::ST_P_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = rwn_pkg::MS_P;
            end
            rwn_pkg::ST_P_WAIT:   cmd.store_p = !status.mul_busy;
            rwn_pkg::ST_T_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = rwn_pkg::MS_T;
            end
            rwn_pkg::ST_T_WAIT:   cmd.store_t = !status.mul_busy;
            rwn_pkg::ST_1_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = rwn_pkg::MS_1;
            end
            rwn_pkg::ST_2_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = rwn_pkg::MS_2;
            end
            rwn_pkg::ST_CMP:      cmd.cmp_update = 1'b1;
            rwn_pkg::ST_DIV_GO:   cmd.div_start = 1'b1;
            rwn_pkg::ST_EMIT:
            begin
                cmd.load_out = emit_go;
                cmd.clear    = emit_go;
            end
            default:
            begin
                cmd.chk = 1'b0;
            end
        endcase
    end

    // state, counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rwn_pkg::ST_ACC;
            k_reg         <= rwn_pkg::PR_NEA;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == rwn_pkg::ST_ACC)
                k_reg <= rwn_pkg::PR_NEA;
            else if (state_reg == rwn_pkg::ST_PROD)
                k_reg <= rwn_pkg::prod_t'(k_reg + 4'd1);

            if (state_reg == rwn_pkg::ST_T_WAIT)
                j_reg <= rwn_pkg::JW'(rwn_pkg::RW - 1);
            else if ((state_reg == rwn_pkg::ST_CMP ||
                      (state_reg == rwn_pkg::ST_CAND && !status.cand_ok)) && j_reg != '0)
                j_reg <= j_reg - 1'b1;

            if (emit_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

@@ sv/rwn_dpath.sv @@
module rwn_dpath #(
    parameter int MAX_SAMPLES = rwn_pkg::DEFAULT_MAX_SAMPLES
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rwn_pkg::cmd_t             cmd,
    input  logic [7:0]                red_a,
    input  logic [7:0]                green_a,
    input  logic [7:0]                blue_a,
    input  logic [7:0]                red_b,
    input  logic [7:0]                green_b,
    input  logic [7:0]                blue_b,
    output rwn_pkg::status_t          status,
    output logic [rwn_pkg::FW-1:0]    dissimilarity,
    output logic [rwn_pkg::FW-1:0]    robust_dissimilarity,
    output logic                      robust_invalid,
    output logic                      overflowed
);

    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SW  = 8 + CW;
    localparam int EW  = 18 + CW;
    localparam int NW  = EW + CW;
    localparam int MBW = NW + 19;
    localparam int LW  = 2 * NW + 40;
    localparam int FW  = rwn_pkg::FW;
    localparam int RW  = rwn_pkg::RW;
    localparam int OW  = rwn_pkg::OW;
    localparam int DVW = rwn_pkg::DVW;
    localparam int DSW = rwn_pkg::DSW;
    localparam int DCW = rwn_pkg::DCW;

    // window accumulators
    logic [CW-1:0]        count_reg;
    logic                 ovf_reg;
    logic [SW-1:0]        sra_reg, sga_reg, sba_reg, srb_reg, sgb_reg, sbb_reg;
    logic [EW-1:0]        ea_reg, eb_reg, x_reg;
    logic                 full;
    logic [17:0]          sq_a, sq_b, sq_x;

    // product phase
    logic [SW-1:0]        op_a;
    logic [EW-1:0]        op_b;
    rwn_pkg::grp_t        grp, prod_grp_reg;
    logic                 sub, prod_sub_reg, prod_vld_reg;
    logic [SW+EW-1:0]     prod_full;
    logic [NW-1:0]        prod_reg;
    logic [NW-1:0]        na_reg, nb_reg;
    logic signed [NW:0]   c_reg;
    logic signed [NW:0]   c_abs;
    logic [NW-1:0]        mag;
    logic [MBW-1:0]       m2;

    // root search
    logic [RW-1:0]        r_reg, cand;
    logic [OW-1:0]        odd;
    logic [LW-1:0]        mul_a_reg, mul_acc_reg, p_reg, t_reg;
    logic [MBW-1:0]       mul_b_reg;

    // robust form
    logic signed [RW:0]   rs;
    logic signed [20:0]   d_w, d_reg;
    logic signed [22:0]   den_w;
    logic [20:0]          d_neg;
    logic [18:0]          d_abs;
    logic                 inv_w, inv_reg, neg_reg;
    logic [DVW-1:0]       quo_reg, neg_q;
    logic [DSW-1:0]       rem_reg, div_reg;
    logic [DCW-1:0]       dcnt_reg;
    logic [DSW:0]         trial;
    logic [FW-1:0]        rob_w;
    logic [FW-1:0]        dis_out_reg, rob_out_reg;
    logic                 inv_out_reg, ovf_out_reg;

    assign full = (count_reg == CW'(MAX_SAMPLES));
    assign sq_a = 18'(16'(red_a) * 16'(red_a)) + 18'(16'(green_a) * 16'(green_a))
                + 18'(16'(blue_a) * 16'(blue_a));
    assign sq_b = 18'(16'(red_b) * 16'(red_b)) + 18'(16'(green_b) * 16'(green_b))
                + 18'(16'(blue_b) * 16'(blue_b));
    assign sq_x = 18'(16'(red_a) * 16'(red_b)) + 18'(16'(green_a) * 16'(green_b))
                + 18'(16'(blue_a) * 16'(blue_b));

    // per-sample accumulation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            sra_reg   <= '0;
            sga_reg   <= '0;
            sba_reg   <= '0;
            srb_reg   <= '0;
            sgb_reg   <= '0;
            sbb_reg   <= '0;
            ea_reg    <= '0;
            eb_reg    <= '0;
            x_reg     <= '0;
        end
        else if (cmd.clear)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            sra_reg   <= '0;
            sga_reg   <= '0;
            sba_reg   <= '0;
            srb_reg   <= '0;
            sgb_reg   <= '0;
            sbb_reg   <= '0;
            ea_reg    <= '0;
            eb_reg    <= '0;
            x_reg     <= '0;
        end
        else if (cmd.acc_en)
        begin
            if (full)
                ovf_reg <= 1'b1;
            else
            begin
                count_reg <= count_reg + 1'b1;
                sra_reg   <= sra_reg + SW'(red_a);
                sga_reg   <= sga_reg + SW'(green_a);
                sba_reg   <= sba_reg + SW'(blue_a);
                srb_reg   <= srb_reg + SW'(red_b);
                sgb_reg   <= sgb_reg + SW'(green_b);
                sbb_reg   <= sbb_reg + SW'(blue_b);
                ea_reg    <= ea_reg + EW'(sq_a);
                eb_reg    <= eb_reg + EW'(sq_b);
                x_reg     <= x_reg + EW'(sq_x);
            end
        end
    end

    // product operand select
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        grp  = rwn_pkg::G_NA;
        sub  = 1'b1;
        case (cmd.prod_k)
            rwn_pkg::PR_NEA:
            begin
                op_a = SW'(count_reg); op_b = ea_reg; grp = rwn_pkg::G_NA; sub = 1'b0;
            end
            rwn_pkg::PR_NEB:
            begin
                op_a = SW'(count_reg); op_b = eb_reg; grp = rwn_pkg::G_NB; sub = 1'b0;
            end
            rwn_pkg::PR_NX:
            begin
                op_a = SW'(count_reg); op_b = x_reg; grp = rwn_pkg::G_C; sub = 1'b0;
            end
            rwn_pkg::PR_SRA: begin op_a = sra_reg; op_b = EW'(sra_reg); grp = rwn_pkg::G_NA; end
            rwn_pkg::PR_SGA: begin op_a = sga_reg; op_b = EW'(sga_reg); grp = rwn_pkg::G_NA; end
            rwn_pkg::PR_SBA: begin op_a = sba_reg; op_b = EW'(sba_reg); grp = rwn_pkg::G_NA; end
            rwn_pkg::PR_SRB: begin op_a = srb_reg; op_b = EW'(srb_reg); grp = rwn_pkg::G_NB; end
            rwn_pkg::PR_SGB: begin op_a = sgb_reg; op_b = EW'(sgb_reg); grp = rwn_pkg::G_NB; end
            rwn_pkg::PR_SBB: begin op_a = sbb_reg; op_b = EW'(sbb_reg); grp = rwn_pkg::G_NB; end
            rwn_pkg::PR_XR:  begin op_a = sra_reg; op_b = EW'(srb_reg); grp = rwn_pkg::G_C;  end
            rwn_pkg::PR_XG:  begin op_a = sga_reg; op_b = EW'(sgb_reg); grp = rwn_pkg::G_C;  end
            rwn_pkg::PR_XB:  begin op_a = sba_reg; op_b = EW'(sbb_reg); grp = rwn_pkg::G_C;  end
            default:         begin op_a = '0; op_b = '0; end
        endcase
    end

    assign prod_full = op_a * op_b;

    // registered product, then accumulate into the centered sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            na_reg       <= '0;
            nb_reg       <= '0;
            c_reg        <= '0;
        end
        else
        begin
            prod_vld_reg <= cmd.prod_issue;
            if (cmd.clear)
            begin
                na_reg <= '0;
                nb_reg <= '0;
                c_reg  <= '0;
            end
            else if (prod_vld_reg)
            begin
                case (prod_grp_reg)
                    rwn_pkg::G_NA: na_reg <= prod_sub_reg ? na_reg - prod_reg : na_reg + prod_reg;
                    rwn_pkg::G_NB: nb_reg <= prod_sub_reg ? nb_reg - prod_reg : nb_reg + prod_reg;
                    default:
                    begin
                        if (prod_sub_reg)
                            c_reg <= c_reg - $signed({1'b0, prod_reg});
                        else
                            c_reg <= c_reg + $signed({1'b0, prod_reg});
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_full[NW-1:0];
        prod_grp_reg <= grp;
        prod_sub_reg <= sub;
    end

    // magnitude of the cross term, doubled target root 3*|c|*2^17
    assign c_abs = c_reg[NW] ? -c_reg : c_reg;
    assign mag   = c_abs[NW-1:0];
    assign m2    = MBW'({mag, 18'b0}) + MBW'({mag, 17'b0});

    // candidate bit for the root search
    assign cand  = r_reg | (RW'(1) << cmd.bit_idx);
    assign odd   = {cand, 1'b0} - OW'(1);

    // bit-serial shift-add multiplier
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_b_reg <= '0;
        else if (cmd.mul_start)
        begin
            case (cmd.mul_sel)
                rwn_pkg::MS_P: mul_b_reg <= MBW'(nb_reg);
                rwn_pkg::MS_T: mul_b_reg <= m2;
                default:       mul_b_reg <= MBW'(odd);
            endcase
        end
        else if (mul_b_reg != '0)
            mul_b_reg <= mul_b_reg >> 1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            mul_acc_reg <= '0;
            case (cmd.mul_sel)
                rwn_pkg::MS_P: mul_a_reg <= LW'(na_reg);
                rwn_pkg::MS_T: mul_a_reg <= LW'(m2);
                rwn_pkg::MS_1: mul_a_reg <= p_reg;
                default:       mul_a_reg <= mul_acc_reg;
            endcase
        end
        else if (mul_b_reg != '0)
        begin
            if (mul_b_reg[0])
                mul_acc_reg <= mul_acc_reg + mul_a_reg;
            mul_a_reg <= mul_a_reg << 1;
        end
        if (cmd.store_p)
            p_reg <= mul_acc_reg;
        if (cmd.store_t)
            t_reg <= mul_acc_reg;
    end

    // root search result
    always_ff @(posedge clk)
    begin
        if (cmd.chk)
            r_reg <= '0;
        else if (cmd.cmp_update && status.cmp_le)
            r_reg <= cand;
    end

    // robust denominator setup
    assign rs    = c_reg[NW] ? -$signed({1'b0, r_reg}) : $signed({1'b0, r_reg});
    assign d_w   = 21'(rwn_pkg::Q16_ONE) - {{2{rs[RW]}}, rs};
    assign den_w = 23'(rwn_pkg::Q16_ONE) + {{1{d_w[20]}}, d_w, 1'b0} + {{2{d_w[20]}}, d_w};
    assign inv_w = den_w[22] || (den_w == '0);
    assign d_neg = -d_w;
    assign d_abs = d_w[20] ? d_neg[18:0] : d_w[18:0];

    // restoring divider, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[DVW-1]} - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.div_start)
            dcnt_reg <= DCW'(DVW);
        else if (dcnt_reg != '0)
            dcnt_reg <= dcnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            d_reg   <= d_w;
            inv_reg <= inv_w;
            neg_reg <= d_w[20];
            quo_reg <= DVW'({d_abs, 17'b0}) + DVW'(den_w[20:0]);
            rem_reg <= '0;
            div_reg <= {den_w[20:0], 1'b0};
        end
        else if (dcnt_reg != '0)
        begin
            if (!trial[DSW])
            begin
                rem_reg <= trial[DSW-1:0];
                quo_reg <= {quo_reg[DVW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DSW-2:0], quo_reg[DVW-1]};
                quo_reg <= {quo_reg[DVW-2:0], 1'b0};
            end
        end
    end

    // sign and saturate the robust quotient
    assign neg_q = DVW'(0) - quo_reg;

    always_comb
    begin
        rob_w = '0;
        if (inv_reg)
            rob_w = '0;
        else if (neg_reg)
            rob_w = (quo_reg > DVW'(-rwn_pkg::OUT_LOW)) ? FW'(rwn_pkg::OUT_LOW) : neg_q[FW-1:0];
        else
            rob_w = (quo_reg > DVW'(rwn_pkg::OUT_HIGH)) ? FW'(rwn_pkg::OUT_HIGH) : quo_reg[FW-1:0];
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            dis_out_reg <= d_reg[FW-1:0];
            rob_out_reg <= rob_w;
            inv_out_reg <= inv_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    assign status.zero_case = (na_reg == '0) || (nb_reg == '0) || (c_reg == '0);
    assign status.cand_ok   = (cand <= RW'(rwn_pkg::DOT_LIMIT));
    assign status.mul_busy  = (mul_b_reg != '0);
    assign status.div_busy  = (dcnt_reg != '0);
    assign status.cmp_le    = (mul_acc_reg <= t_reg);

    assign dissimilarity        = dis_out_reg;
    assign robust_dissimilarity = rob_out_reg;
    assign robust_invalid       = inv_out_reg;
    assign overflowed           = ovf_out_reg;

endmodule

@@ sv/rgb_window_ncc.sv @@
// rgb_window_ncc: dissimilarity of two RGB texture windows by normalized cross correlation
//
// samples (sink): one word per sample pair, red/green/blue of window a and of window b,
//   last_sample marks the final pair. Pairs past MAX_SAMPLES are dropped and flagged.
// result (source): one word per window: dissimilarity, robust_dissimilarity (signed Q16),
//   robust_invalid and overflowed.
// Throughput: one sample pair per cycle while a window accumulates.
// After the last pair the block stops taking words while it works out the result:
//   the product terms, then a bit-serial shift-add multiplier for the product of the
//   two energies, for the squared target and for two multiplies in each of the 18 root
//   search steps whose candidate stays within DOT_LIMIT, then a restoring divider.
//   A flat window skips the search.
// The result sits in an output register; the next window accumulates while it waits.
// A stalled receiver only holds the block back when a second result is ready.
// Reset clears all sums, the sample count, the overflow flag and the output valid.
module rgb_window_ncc #(
    parameter int MAX_SAMPLES = rwn_pkg::DEFAULT_MAX_SAMPLES
) (
    input  logic      clk,
    input  logic      rst_n,
    rwn_in_if.sink    samples,
    rwn_out_if.source result
);

    rwn_pkg::cmd_t    cmd;
    rwn_pkg::status_t status;

    // sequencer
    rwn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_last   (samples.last_sample),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (samples.ready),
        .out_valid (result.valid)
    );

    // arithmetic
    rwn_dpath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dpath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .red_a                (samples.red_a),
        .green_a              (samples.green_a),
        .blue_a               (samples.blue_a),
        .red_b                (samples.red_b),
        .green_b              (samples.green_b),
        .blue_b               (samples.blue_b),
        .status               (status),
        .dissimilarity        (result.dissimilarity),
        .robust_dissimilarity (result.robust_dissimilarity),
        .robust_invalid       (result.robust_invalid),
        .overflowed           (result.overflowed)
    );

    // checks
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.robust_invalid |-> result.robust_dissimilarity == '0)
        else $error("robust value not forced to zero");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready && samples.last_sample |=> !samples.ready)
        else $error("sample taken during result computation");

    a_dis_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.dissimilarity >= -20'sd131072
                      && result.dissimilarity <= 20'sd262144)
        else $error("dissimilarity out of range");

endmodule
